// ===== rtl/square_noise_sound_generator_unit_defines.svh =====
// Assertion macros shared by the square/noise sound generator RTL.
`ifndef SQUARE_NOISE_SOUND_GENERATOR_UNIT_DEFINES_SVH
`define SQUARE_NOISE_SOUND_GENERATOR_UNIT_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define SNSG_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sound generator check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define SNSG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sound generator check failed");

`endif

// ===== rtl/snsg_pkg.sv =====
// Constants, types and the level table of the square/noise sound generator.
package snsg_pkg;

    localparam int LevelDiv  = 14;
    localparam int LEVEL_W   = 12;
    localparam int SAMPLE_W  = 14;
    localparam int PERIOD_W  = 10;
    localparam int ATT_W     = 4;
    localparam int NUM_CH    = 4;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = SAMPLE_W'(4 * (32767 / LevelDiv));

    // Beat kinds
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Channel codes
    localparam logic [1:0] CH_TONE2 = 2'd2;
    localparam logic [1:0] CH_NOISE = 2'd3;

    // Noise rate codes
    localparam logic [1:0] RATE_16   = 2'd0;
    localparam logic [1:0] RATE_32   = 2'd1;
    localparam logic [1:0] RATE_64   = 2'd2;

    localparam logic [15:0] NOISE_SEED = 16'h8000;

    typedef logic [PERIOD_W-1:0] period_t;
    typedef logic [ATT_W-1:0]    att_t;
    typedef logic [LEVEL_W-1:0]  level_t;

    // Map attenuation to output level; full attenuation is silent.
    function automatic level_t level_of(input att_t att);
        level_t lvl;
        case (att)
            4'd0:    lvl = LEVEL_W'(32767 / LevelDiv);
            4'd1:    lvl = LEVEL_W'(26028 / LevelDiv);
            4'd2:    lvl = LEVEL_W'(20675 / LevelDiv);
            4'd3:    lvl = LEVEL_W'(16422 / LevelDiv);
            4'd4:    lvl = LEVEL_W'(13045 / LevelDiv);
            4'd5:    lvl = LEVEL_W'(10362 / LevelDiv);
            4'd6:    lvl = LEVEL_W'(8231 / LevelDiv);
            4'd7:    lvl = LEVEL_W'(6568 / LevelDiv);
            4'd8:    lvl = LEVEL_W'(5193 / LevelDiv);
            4'd9:    lvl = LEVEL_W'(4125 / LevelDiv);
            4'd10:   lvl = LEVEL_W'(3277 / LevelDiv);
            4'd11:   lvl = LEVEL_W'(2603 / LevelDiv);
            4'd12:   lvl = LEVEL_W'(2067 / LevelDiv);
            4'd13:   lvl = LEVEL_W'(1642 / LevelDiv);
            4'd14:   lvl = LEVEL_W'(1304 / LevelDiv);
            default: lvl = '0;
        endcase
        return lvl;
    endfunction

endpackage

// ===== rtl/square_noise_sound_generator_unit.sv =====
// Top level of the square/noise sound generator: three tones and one noise channel.
//
// Usage
//   Input channel (in_valid/in_ready, op, data): op = 0 carries a register byte
//   in the latch/data protocol, op = 1 is one generator clock tick (data unused).
//   Output channel (out_valid/out_ready, sample): one 14-bit unsigned level
//   sum for every tick beat; write beats produce no output beat.
//   Path: an accepted tick waits in the input register, and its sample is then
//   loaded into the sample register, from which it is shown on the output.
//   Throughput: one beat per cycle unless a tick stalls; the tone/noise counter update and the
//   four-entry level sum sit between the input register and the sample
//   register, so each beat takes one pass through that logic.
//   Stall: when the sample register holds an untaken beat, a tick waiting in
//   the input register holds and in_ready drops; a write there still goes
//   through, since it needs no output slot.
//   Reset (rst_n low, asynchronous): all channels silent (attenuation 15),
//   periods, counters, phases, noise shift register and latch cleared, both
//   pipeline registers empty. The first beat may be taken right after reset.
module square_noise_sound_generator_unit
    import snsg_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                op,
    input  logic [7:0]          data,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [SAMPLE_W-1:0] sample
);

`include "square_noise_sound_generator_unit_defines.svh"

    // Input register
    logic       s1_valid_reg;
    logic       s1_op_reg;
    logic [7:0] s1_data_reg;
    logic       s1_go;

    // Generator state
    att_t       attenuation_reg     [NUM_CH];
    period_t    period_reload_reg   [NUM_CH];
    period_t    period_count_reg    [NUM_CH];
    logic [NUM_CH-1:0] phase_bit_reg;
    logic       noise_level_reg;
    logic [15:0] shift_reg_reg;
    logic       white_mode_reg;
    logic       follow_tone_two_reg;
    logic [2:0] latched_select_reg;

    att_t       attenuation_next    [NUM_CH];
    period_t    period_reload_next  [NUM_CH];
    period_t    period_count_next   [NUM_CH];
    logic [NUM_CH-1:0] phase_bit_next;
    logic       noise_level_next;
    logic [15:0] shift_reg_next;
    logic       white_mode_next;
    logic       follow_tone_two_next;
    logic [2:0] latched_select_next;

    // Result register
    logic                out_valid_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [SAMPLE_W-1:0] sum_next;

    // Advance the input register: writes always, ticks when the output slot frees
    assign s1_go    = s1_valid_reg && ((s1_op_reg == OP_WRITE) || !out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_op_reg   <= op;
            s1_data_reg <= data;
        end
    end

    // Compute the next state and the sample for the beat in the input register
    always_comb
    begin
        logic [1:0]  ch;
        period_t     dec;
        logic [15:0] rot;

        attenuation_next     = attenuation_reg;
        period_reload_next   = period_reload_reg;
        period_count_next    = period_count_reg;
        phase_bit_next       = phase_bit_reg;
        noise_level_next     = noise_level_reg;
        shift_reg_next       = shift_reg_reg;
        white_mode_next      = white_mode_reg;
        follow_tone_two_next = follow_tone_two_reg;
        latched_select_next  = latched_select_reg;
        ch                   = s1_data_reg[6:5];
        dec                  = '0;
        rot                  = '0;

        if (s1_op_reg == OP_TICK)
        begin
            // Step each counter; reload and toggle phase when it hits zero
            for (int i = 0; i < NUM_CH; i++)
            begin
                dec = (period_count_reg[i] != '0) ? period_count_reg[i] - 1'b1
                                                   : period_count_reg[i];
                period_count_next[i] = dec;
                if (dec == '0)
                begin
                    period_count_next[i] = period_reload_reg[i];
                    phase_bit_next[i]    = ~phase_bit_reg[i];
                end
            end
            // Shift the noise register on a rising noise half-period
            if (phase_bit_next[CH_NOISE] && !phase_bit_reg[CH_NOISE])
            begin
                noise_level_next = shift_reg_reg[0];
                rot = {shift_reg_reg[0], shift_reg_reg[15:1]};
                if (white_mode_reg && rot[6])
                begin
                    rot[15] = ~rot[15];
                end
                shift_reg_next = rot;
            end
        end
        else if (s1_data_reg[7])
        begin
            // Latch byte
            latched_select_next = s1_data_reg[6:4];
            if (s1_data_reg[4])
            begin
                attenuation_next[ch] = s1_data_reg[3:0];
            end
            else if (ch == CH_NOISE)
            begin
                follow_tone_two_next = 1'b0;
                case (s1_data_reg[1:0])
                    RATE_16: period_reload_next[CH_NOISE] = PERIOD_W'(16);
                    RATE_32: period_reload_next[CH_NOISE] = PERIOD_W'(32);
                    RATE_64: period_reload_next[CH_NOISE] = PERIOD_W'(64);
                    default:
                    begin
                        period_reload_next[CH_NOISE] = period_reload_reg[CH_TONE2];
                        follow_tone_two_next         = 1'b1;
                    end
                endcase
                white_mode_next = s1_data_reg[2];
                shift_reg_next  = NOISE_SEED;
            end
            else
            begin
                period_reload_next[ch] = {period_reload_reg[ch][PERIOD_W-1:4],
                                          s1_data_reg[3:0]};
                if (ch == CH_TONE2 && follow_tone_two_reg)
                begin
                    period_reload_next[CH_NOISE] = period_reload_next[CH_TONE2];
                end
            end
        end
        else if (!latched_select_reg[0])
        begin
            // Data byte: high tone bits of the latched tone channel
            ch = latched_select_reg[2:1];
            if (ch != CH_NOISE)
            begin
                period_reload_next[ch] = {s1_data_reg[5:0], period_reload_reg[ch][3:0]};
                if (ch == CH_TONE2 && follow_tone_two_reg)
                begin
                    period_reload_next[CH_NOISE] = period_reload_next[CH_TONE2];
                end
            end
        end

        // Sum the levels of active tones and the noise output
        sum_next = (phase_bit_next[0] ? SAMPLE_W'(level_of(attenuation_reg[0])) : '0)
                 + (phase_bit_next[1] ? SAMPLE_W'(level_of(attenuation_reg[1])) : '0)
                 + (phase_bit_next[2] ? SAMPLE_W'(level_of(attenuation_reg[2])) : '0)
                 + (noise_level_next  ? SAMPLE_W'(level_of(attenuation_reg[3])) : '0);
    end

    // Commit the generator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CH; i++)
            begin
                attenuation_reg[i]   <= '1;
                period_reload_reg[i] <= '0;
                period_count_reg[i]  <= '0;
            end
            phase_bit_reg       <= '0;
            noise_level_reg     <= 1'b0;
            shift_reg_reg       <= '0;
            white_mode_reg      <= 1'b0;
            follow_tone_two_reg <= 1'b0;
            latched_select_reg  <= '0;
        end
        else if (s1_go)
        begin
            attenuation_reg     <= attenuation_next;
            period_reload_reg   <= period_reload_next;
            period_count_reg    <= period_count_next;
            phase_bit_reg       <= phase_bit_next;
            noise_level_reg     <= noise_level_next;
            shift_reg_reg       <= shift_reg_next;
            white_mode_reg      <= white_mode_next;
            follow_tone_two_reg <= follow_tone_two_next;
            latched_select_reg  <= latched_select_next;
        end
    end

    // Load the sample register on a tick, drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_go && (s1_op_reg == OP_TICK))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && (s1_op_reg == OP_TICK))
        begin
            sample_reg <= sum_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;

    // Checks
    `SNSG_ASSERT_NEXT(a_write_no_beat, clk, rst_n,
        s1_valid_reg && (s1_op_reg == OP_WRITE) && (!out_valid_reg || out_ready),
        !out_valid_reg)
    `SNSG_ASSERT_NEXT(a_tick_holds, clk, rst_n,
        s1_valid_reg && (s1_op_reg == OP_TICK) && out_valid_reg && !out_ready,
        s1_valid_reg && (s1_op_reg == OP_TICK))
    `SNSG_ASSERT_SAME(a_sample_range, clk, rst_n,
        out_valid_reg,
        sample_reg <= SAMPLE_MAX)
    `SNSG_ASSERT_NEXT(a_noise_seed, clk, rst_n,
        s1_go && (s1_op_reg == OP_WRITE) && s1_data_reg[7] && !s1_data_reg[4]
            && (s1_data_reg[6:5] == CH_NOISE),
        shift_reg_reg == NOISE_SEED)

endmodule
